// File: sv/iir5_pkg.sv
// shared constants and types for the fifth-order iir dac filter
// coefficient set, register indexes and fixed-point widths; no dependencies
`timescale 1ns / 1ps

package iir5_pkg;

	localparam int SAMPLE_BITS    = 12;
	localparam int FILTER_ORDER   = 5;
	localparam int COEF_W         = 32;
	localparam int NUM_B          = 6;
	localparam int NUM_A          = 5;
	localparam int Y_W            = 40;
	localparam int Y_FRAC         = 16;
	localparam int ACC_FRAC_SHIFT = 8;
	localparam int ACC_W          = 59;
	localparam int DAC_BITS       = 12;
	localparam int DAC_W          = 16;
	localparam int CFG_DATA_W     = 64;
	localparam int CFG_IDX_W      = 3;

	localparam logic [DAC_BITS-1:0]       DAC_MAX  = 12'h0FFF;
	localparam logic [DAC_W-DAC_BITS-1:0] DAC_CTRL = 4'b0111;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [Y_W-1:0]    y_t;

	// b[0..5] feedforward, a[0..4] hold a1..a5
	typedef struct packed {
		logic [NUM_B-1:0][COEF_W-1:0] b;
		logic [NUM_A-1:0][COEF_W-1:0] a;
	} coef_set_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_B0_B1 = 3'd0,
		REG_B2_B3 = 3'd1,
		REG_B4_B5 = 3'd2,
		REG_A1_A2 = 3'd3,
		REG_A3_A4 = 3'd4,
		REG_A5    = 3'd5
	} cfg_reg_t;

endpackage

// File: sv/iir5_core.sv
// filter arithmetic and tap history for the fifth-order iir dac filter
// one output per step from the current sample and stored history; uses iir5_pkg
`timescale 1ns / 1ps

module iir5_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic [iir5_pkg::SAMPLE_BITS-1:0]   x,
	input  iir5_pkg::coef_set_t                coef,
	output logic [iir5_pkg::DAC_BITS-1:0]      dac_val
);
	import iir5_pkg::*;

	localparam int FF_W  = COEF_W + SAMPLE_BITS + 1;
	localparam int YH_W  = Y_W - Y_FRAC;
	localparam int FBH_W = COEF_W + YH_W;
	localparam int FBL_W = COEF_W + Y_FRAC + 1;
	localparam int SUM_W = ACC_W - ACC_FRAC_SHIFT;

	logic [SAMPLE_BITS-1:0] xh_q [FILTER_ORDER];
	y_t                     yh_q [FILTER_ORDER];
	y_t                     y_new;

	always_comb begin
		logic signed [ACC_W-1:0] acc;
		logic signed [FF_W-1:0]  ff;
		logic signed [FBH_W-1:0] fbh;
		logic signed [FBL_W-1:0] fbl;
		logic signed [SUM_W-1:0] sum;
		ff  = $signed(coef.b[0]) * $signed({1'b0, x});
		acc = ACC_W'(ff);
		for (int k = 1; k <= FILTER_ORDER; k++) begin
			ff  = $signed(coef.b[k]) * $signed({1'b0, xh_q[k-1]});
			// feedback product split in high and low parts of y, low part floored
			fbh = $signed(coef.a[k-1]) * $signed(yh_q[k-1][Y_W-1:Y_FRAC]);
			fbl = $signed(coef.a[k-1]) * $signed({1'b0, yh_q[k-1][Y_FRAC-1:0]});
			acc = acc + ACC_W'(ff) - ACC_W'(fbh) - ACC_W'(fbl >>> Y_FRAC);
		end
		sum = $signed(acc[ACC_W-1:ACC_FRAC_SHIFT]);
		// saturate to the stored history range
		if ((&sum[SUM_W-1:Y_W-1]) || !(|sum[SUM_W-1:Y_W-1])) begin
			y_new = sum[Y_W-1:0];
		end else if (sum[SUM_W-1]) begin
			y_new = {1'b1, {(Y_W-1){1'b0}}};
		end else begin
			y_new = {1'b0, {(Y_W-1){1'b1}}};
		end
		if (y_new[Y_W-1]) begin
			dac_val = '0;
		end else if (|y_new[Y_W-2:Y_FRAC+DAC_BITS]) begin
			dac_val = DAC_MAX;
		end else begin
			dac_val = y_new[Y_FRAC+DAC_BITS-1:Y_FRAC];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FILTER_ORDER; i++) begin
				xh_q[i] <= '0;
				yh_q[i] <= '0;
			end
		end else if (step) begin
			for (int i = FILTER_ORDER - 1; i > 0; i--) begin
				xh_q[i] <= xh_q[i-1];
				yh_q[i] <= yh_q[i-1];
			end
			xh_q[0] <= x;
			yh_q[0] <= y_new;
		end
	end

endmodule

// File: sv/iir_order5_dac_sample_filter.sv
// top level of the fifth-order direct-form-i iir filter with dac word output
// handshakes, coefficient registers, input and result registers; uses iir5_pkg, iir5_core
//
//  channel   direction  handshake                    payload
//  sample    in         sample_valid/sample_ready    sample[11:0]
//  dac       out        dac_valid/dac_ready          dac_word[15:0]
//  cfg       in         cfg_wr_en                    cfg_index[2:0], cfg_data[63:0]
//
// one item per cycle while the dac side is ready; items pass the input register, then
// the result register; the filter sum and its feedback from the previous output are
// combinational between the input register and the result register
// asynchronous reset clears coefficients, history and valid flags
// a stall on dac holds both registers; a new item is still taken when the input register frees
`timescale 1ns / 1ps

module iir_order5_dac_sample_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [iir5_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [iir5_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic [iir5_pkg::SAMPLE_BITS-1:0]    sample,
	output logic                                dac_valid,
	input  logic                                dac_ready,
	output logic [iir5_pkg::DAC_W-1:0]          dac_word
);
	import iir5_pkg::*;

	coef_set_t              coef_q;
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   dac_valid_q;
	logic [DAC_W-1:0]       dac_word_q;
	logic                   advance;
	logic [DAC_BITS-1:0]    dac_val;

	assign advance      = valid_s1 && (!dac_valid_q || dac_ready);
	assign sample_ready = !valid_s1 || advance;
	assign dac_valid    = dac_valid_q;
	assign dac_word     = dac_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_B0_B1: begin
					coef_q.b[0] <= cfg_data[COEF_W-1:0];
					coef_q.b[1] <= cfg_data[2*COEF_W-1:COEF_W];
				end
				REG_B2_B3: begin
					coef_q.b[2] <= cfg_data[COEF_W-1:0];
					coef_q.b[3] <= cfg_data[2*COEF_W-1:COEF_W];
				end
				REG_B4_B5: begin
					coef_q.b[4] <= cfg_data[COEF_W-1:0];
					coef_q.b[5] <= cfg_data[2*COEF_W-1:COEF_W];
				end
				REG_A1_A2: begin
					coef_q.a[0] <= cfg_data[COEF_W-1:0];
					coef_q.a[1] <= cfg_data[2*COEF_W-1:COEF_W];
				end
				REG_A3_A4: begin
					coef_q.a[2] <= cfg_data[COEF_W-1:0];
					coef_q.a[3] <= cfg_data[2*COEF_W-1:COEF_W];
				end
				REG_A5: begin
					coef_q.a[4] <= cfg_data[COEF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			dac_valid_q <= 1'b0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (advance) begin
				dac_valid_q <= 1'b1;
			end else if (dac_ready) begin
				dac_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			sample_s1 <= sample;
		end
		if (advance) begin
			dac_word_q <= {DAC_CTRL, dac_val};
		end
	end

	iir5_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.x       (sample_s1),
		.coef    (coef_q),
		.dac_val (dac_val)
	);

`ifndef NO_ASSERTIONS
	// a waiting item in the input register is neither lost nor altered
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(sample_s1))
		else $error("input register item lost while stalled");

	// a processed item always lands in the result register
	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> dac_valid)
		else $error("result missing after advance");

	// input side only blocks when both stages are full and the output stalls
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> valid_s1 && dac_valid && !dac_ready)
		else $error("input blocked without a full pipeline");

	// control nibble always present on a shown result
	a_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		dac_valid |-> dac_word[DAC_W-1:DAC_BITS] == DAC_CTRL)
		else $error("dac control bits wrong");
`endif

endmodule

// File: test/tb_iir_order5_dac_sample_filter.sv
// self-checking bench for the fifth-order iir dac filter: bursty sample stream, stalling dac side
// every dac word is predicted by a fixed-point filter kept here; needs iir5_pkg and the filter rtl
`timescale 1ns / 1ps

module tb_iir_order5_dac_sample_filter;

	import iir5_pkg::*;

	localparam int PROD_W        = 96;
	localparam int SETTLE_CYCLES = 6;
	localparam int LONG_HOLD     = 300;
	localparam int CYCLE_LIMIT   = 200000;

	// indexes past the last register, the block must ignore them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	// Q8.24 coefficients
	localparam logic [COEF_W-1:0] Q_ONE        = 32'h0100_0000;
	localparam logic [COEF_W-1:0] Q_MAX        = 32'h7FFF_FFFF;
	localparam logic [COEF_W-1:0] Q_MIN        = 32'h8000_0000;
	localparam logic [COEF_W-1:0] Q_SIXTH      = 32'h002A_AAAB;
	localparam logic [COEF_W-1:0] Q_QUARTER    = 32'h0040_0000;
	localparam logic [COEF_W-1:0] Q_NEG_0P75   = 32'hFF40_0000;
	localparam logic [COEF_W-1:0] Q_TENTH      = 32'h0019_999A;
	localparam logic [COEF_W-1:0] Q_NEG_1P6    = 32'hFE66_6666;
	localparam logic [COEF_W-1:0] Q_0P8        = 32'h00CC_CCCD;

	localparam logic signed [PROD_W-1:0] Y_HI = {{(PROD_W-Y_W+1){1'b0}}, {(Y_W-1){1'b1}}};
	localparam logic signed [PROD_W-1:0] Y_LO = -Y_HI - 1;

	typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                   sample_valid = 1'b0;
	logic                   sample_ready;
	logic [SAMPLE_BITS-1:0] sample       = '0;
	logic                   dac_valid;
	logic                   dac_ready    = 1'b0;
	logic [DAC_W-1:0]       dac_word;

	// predictor state
	coef_t                  b_coef [0:NUM_B-1];
	coef_t                  a_coef [1:NUM_A];
	logic [SAMPLE_BITS-1:0] sample_hist [0:FILTER_ORDER-1];
	y_t                     y_hist [0:FILTER_ORDER-1];

	logic [SAMPLE_BITS-1:0] pending_samples [$];
	logic [DAC_W-1:0]       dac_expected [$];
	logic [DAC_W-1:0]       want_word;
	logic                   item_taken = 1'b0;

	int errors        = 0;
	int samples_in    = 0;
	int words_checked = 0;
	int sets_loaded   = 0;
	int holds_asked   = 0;
	int holds_done    = 0;
	int cycle_count   = 0;

	// sender and receiver pacing
	int burst_left = 0;
	int gap_left   = 0;
	int hold_left  = 0;
	int mode_left  = 0;
	int rx_tick    = 0;
	rx_mode_t rx_mode = RX_OPEN;

	iir_order5_dac_sample_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.dac_valid    (dac_valid),
		.dac_ready    (dac_ready),
		.dac_word     (dac_word)
	);

	always #5 clk = ~clk;

	// one filter step: feedforward exact, each feedback product floored to Q.24,
	// then the sum floored to Q.16 and saturated to 40 bits
	function automatic logic [DAC_W-1:0] filter_sample(input logic [SAMPLE_BITS-1:0] x);
		logic signed [PROD_W-1:0] acc;
		logic signed [PROD_W-1:0] fb;
		y_t                       y;
		logic [DAC_BITS-1:0]      level;
		acc = b_coef[0] * $signed({1'b0, x});
		for (int k = 1; k <= FILTER_ORDER; k++) begin
			acc = acc + b_coef[k] * $signed({1'b0, sample_hist[k-1]});
			fb  = a_coef[k] * y_hist[k-1];
			acc = acc - (fb >>> Y_FRAC);
		end
		acc = acc >>> ACC_FRAC_SHIFT;
		if (acc > Y_HI) begin
			y = Y_HI[Y_W-1:0];
		end else if (acc < Y_LO) begin
			y = Y_LO[Y_W-1:0];
		end else begin
			y = acc[Y_W-1:0];
		end
		for (int k = FILTER_ORDER - 1; k > 0; k--) begin
			sample_hist[k] = sample_hist[k-1];
			y_hist[k]      = y_hist[k-1];
		end
		sample_hist[0] = x;
		y_hist[0]      = y;
		if (y < 0) begin
			level = '0;
		end else if (y[Y_W-1:Y_FRAC] > DAC_MAX) begin
			level = DAC_MAX;
		end else begin
			level = y[Y_FRAC+DAC_BITS-1:Y_FRAC];
		end
		return {DAC_CTRL, level};
	endfunction

	// drives one register write; the enable is left high for a following write
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_B0_B1: begin
				b_coef[0] = data[31:0];
				b_coef[1] = data[63:32];
			end
			REG_B2_B3: begin
				b_coef[2] = data[31:0];
				b_coef[3] = data[63:32];
			end
			REG_B4_B5: begin
				b_coef[4] = data[31:0];
				b_coef[5] = data[63:32];
			end
			REG_A1_A2: begin
				a_coef[1] = data[31:0];
				a_coef[2] = data[63:32];
			end
			REG_A3_A4: begin
				a_coef[3] = data[31:0];
				a_coef[4] = data[63:32];
			end
			REG_A5: begin
				a_coef[5] = data[31:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic program_filter(input coef_set_t cs, input bit with_spares);
		logic [31:0] junk;
		junk = $urandom();
		cfg_write(REG_B0_B1, {cs.b[1], cs.b[0]});
		cfg_write(REG_B2_B3, {cs.b[3], cs.b[2]});
		cfg_write(REG_B4_B5, {cs.b[5], cs.b[4]});
		cfg_write(REG_A1_A2, {cs.a[1], cs.a[0]});
		cfg_write(REG_A3_A4, {cs.a[3], cs.a[2]});
		// upper half of a5 carries junk that must be dropped
		cfg_write(REG_A5, {junk, cs.a[4]});
		if (with_spares) begin
			cfg_write(REG_SPARE_6, {$urandom(), $urandom()});
			cfg_write(REG_SPARE_7, {$urandom(), $urandom()});
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sets_loaded++;
	endtask

	// mix of full-range noise, rail values and a slow random walk
	task automatic queue_random_samples(input int n);
		int walk;
		int pick;
		walk = $urandom_range(0, 4095);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				pending_samples.push_back(SAMPLE_BITS'($urandom_range(0, 4095)));
			end else if (pick < 7) begin
				pending_samples.push_back(pick == 5 ? 12'h000 : 12'hFFF);
			end else begin
				walk = walk + $urandom_range(0, 256) - 128;
				if (walk < 0) walk = 0;
				if (walk > 4095) walk = 4095;
				pending_samples.push_back(walk[SAMPLE_BITS-1:0]);
			end
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_samples.size() != 0 || sample_valid || dac_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// sender: bursts of random length with random gaps
	always @(negedge clk) begin
		if (!sample_valid || item_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				sample_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				sample_valid <= 1'b1;
				sample       <= pending_samples.pop_front();
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 32);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern picked at random from four modes, long hold-off on request
	always @(negedge clk) begin
		rx_tick++;
		if (holds_done != holds_asked) begin
			hold_left = LONG_HOLD;
			holds_done++;
		end
		if (hold_left > 0) begin
			hold_left--;
			dac_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'(2'($urandom_range(0, 3)));
				mode_left = $urandom_range(10, 80);
			end
			mode_left--;
			case (rx_mode)
				RX_OPEN:  dac_ready <= 1'b1;
				RX_LIGHT: dac_ready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY: dac_ready <= ($urandom_range(0, 9) < 3);
				RX_BEAT:  dac_ready <= ((rx_tick % 3) != 0);
				default:  dac_ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		item_taken <= arst_n && sample_valid && sample_ready;
		if (arst_n) begin
			if (sample_valid && sample_ready) begin
				dac_expected.push_back(filter_sample(sample));
				samples_in++;
			end
			if (dac_valid && dac_ready) begin
				if (dac_expected.size() == 0) begin
					$error("dac_word: no item expected, got %h", dac_word);
					errors++;
				end else begin
					want_word = dac_expected.pop_front();
					words_checked++;
					if (dac_word !== want_word) begin
						$error("dac_word mismatch: expected %h, actual %h", want_word, dac_word);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_iir_order5_dac_sample_filter: errors");
			$finish;
		end
	end

	initial begin
		coef_set_t              cs;
		logic [SAMPLE_BITS-1:0] corner_samples [0:7];
		corner_samples = '{12'h000, 12'hFFF, 12'h001, 12'h800,
			12'h7FF, 12'hAAA, 12'h555, 12'hFFE};
		for (int i = 0; i < NUM_B; i++) b_coef[i] = '0;
		for (int i = 1; i <= NUM_A; i++) a_coef[i] = '0;
		for (int i = 0; i < FILTER_ORDER; i++) begin
			sample_hist[i] = '0;
			y_hist[i]      = '0;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// coefficients straight out of reset are zero
		for (int i = 0; i < 4; i++) pending_samples.push_back(corner_samples[i * 2 + 1 - (i & 1)]);
		wait_drained();

		// pass-through, output equals input
		cs = '0;
		cs.b[0] = Q_ONE;
		program_filter(cs, 1'b0);
		for (int i = 0; i < 8; i++) pending_samples.push_back(corner_samples[i]);
		wait_drained();

		// largest gains with positive feedback: history saturates high, output clamps to 4095
		for (int k = 0; k < NUM_B; k++) cs.b[k] = Q_MAX;
		for (int k = 0; k < NUM_A; k++) cs.a[k] = Q_MIN;
		program_filter(cs, 1'b0);
		for (int i = 0; i < 6; i++) pending_samples.push_back(i < 4 ? 12'hFFF : 12'h000);
		wait_drained();

		// most negative feedforward gains, largest feedback: history swings between the rails, output clamps to zero or 4095
		for (int k = 0; k < NUM_B; k++) cs.b[k] = Q_MIN;
		for (int k = 0; k < NUM_A; k++) cs.a[k] = Q_MAX;
		program_filter(cs, 1'b0);
		for (int i = 0; i < 5; i++) pending_samples.push_back(i < 3 ? 12'hFFF : 12'h000);
		wait_drained();

		// six-tap moving average, writes to unused indexes follow
		cs = '0;
		for (int k = 0; k < NUM_B; k++) cs.b[k] = Q_SIXTH;
		program_filter(cs, 1'b1);
		queue_random_samples(140);
		wait_drained();

		// first-order low pass, with a long dac hold-off while samples keep coming
		cs = '0;
		cs.b[0] = Q_QUARTER;
		cs.a[0] = Q_NEG_0P75;
		program_filter(cs, 1'b0);
		queue_random_samples(140);
		holds_asked++;
		wait_drained();

		// resonant second-order section
		cs = '0;
		cs.b[0] = Q_TENTH;
		cs.a[0] = Q_NEG_1P6;
		cs.a[1] = Q_0P8;
		program_filter(cs, 1'b0);
		queue_random_samples(140);
		wait_drained();

		// small random coefficients, two sets
		for (int s = 0; s < 2; s++) begin
			for (int k = 0; k < NUM_B; k++) cs.b[k] = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
			for (int k = 0; k < NUM_A; k++) cs.a[k] = $urandom_range(0, 32'h0066_6666) - 32'h0033_3333;
			program_filter(cs, 1'b1);
			queue_random_samples(70);
			wait_drained();
		end

		// fully random registers, mostly saturating
		for (int k = 0; k < NUM_B; k++) cs.b[k] = $urandom();
		for (int k = 0; k < NUM_A; k++) cs.a[k] = $urandom();
		program_filter(cs, 1'b1);
		queue_random_samples(140);
		wait_drained();

		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("%0d samples filtered, %0d dac words checked", samples_in, words_checked);
		$display("%0d coefficient sets incl. rails and saturation, %0d long dac hold-off",
			sets_loaded, holds_done);
		if (errors == 0) begin
			$display("tb_iir_order5_dac_sample_filter: clean");
		end else begin
			$display("tb_iir_order5_dac_sample_filter: errors");
		end
		$finish;
	end

endmodule
